@@ design/mme_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the matrix multiply engine.
package mme_pkg;

	localparam int MAX_DIM_DEF   = 8;
	localparam int ELEM_BITS_DEF = 32;

	localparam int KIND_W  = 2;
	localparam int IDX_W   = 3;
	localparam int DIM_W   = 4;
	localparam int ELEM_W  = 32;
	localparam int PROD_W  = 64;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_WR_A  = 2'd0,
		KIND_WR_B  = 2'd1,
		KIND_START = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_A_ROWS = 2'd0,
		REG_A_COLS = 2'd1,
		REG_B_ROWS = 2'd2,
		REG_B_COLS = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_ERR
	} state_t;

	// Tag travelling alongside each multiply-accumulate step.
	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             first;
		logic             last_k;
		logic             last_elem;
	} mac_tag_t;

	// Zero reads as one, anything above the maximum as the maximum.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
	                                               input logic [DIM_W-1:0] max_dim);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > max_dim)
			r = max_dim;
		return r;
	endfunction

endpackage

@@ design/mme_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module mme_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/matrix_multiply_engine.sv @@
`timescale 1ns / 1ps
// Top level: element stores for A and B, and the multiply-accumulate sequencer.
// Element writes: one item a cycle while idle, stored on the accepting edge.
// Start: one MAC step a cycle unless the output stalls, a_rows * b_cols * a_cols
//   steps, set by the single read port of each store; results pass the store
//   read, product and output registers. A dimension mismatch gives an error item.
// Input is held off from a start until its last MAC step has been issued.
// Reset clears control, the accumulator and the dimension registers (to 1);
//   store contents are undefined until written.
module matrix_multiply_engine #(
	parameter int MAX_DIM   = mme_pkg::MAX_DIM_DEF,
	parameter int ELEM_BITS = mme_pkg::ELEM_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input items
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mme_pkg::KIND_W-1:0]    kind,
	input  logic [mme_pkg::IDX_W-1:0]     row_index,
	input  logic [mme_pkg::IDX_W-1:0]     col_index,
	input  logic [mme_pkg::ELEM_W-1:0]    element,
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mme_pkg::DIM_W-1:0]     cfg_data,
	// result items
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mme_pkg::IDX_W-1:0]     out_row,
	output logic [mme_pkg::IDX_W-1:0]     out_col,
	output logic [mme_pkg::PROD_W-1:0]    product,
	output logic                          last,
	output logic                          dim_error
);

	// Only the low ELEM_BITS bits of an element, at most 32, ever reach the stores.
	localparam int STORE_W = (ELEM_BITS < mme_pkg::ELEM_W) ? ELEM_BITS : mme_pkg::ELEM_W;
	localparam int DEPTH   = MAX_DIM * MAX_DIM;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MUL_W   = 2 * STORE_W;
	localparam logic [mme_pkg::DIM_W-1:0] MAX_D = mme_pkg::DIM_W'(MAX_DIM);

	// ---------------------------------------------------------------- config
	logic [mme_pkg::DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [mme_pkg::DIM_W-1:0] ar_c, ac_c, br_c, bc_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= mme_pkg::DIM_W'(1);
			a_cols_q <= mme_pkg::DIM_W'(1);
			b_rows_q <= mme_pkg::DIM_W'(1);
			b_cols_q <= mme_pkg::DIM_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (mme_pkg::reg_idx_t'(cfg_index))
				mme_pkg::REG_A_ROWS: a_rows_q <= cfg_data;
				mme_pkg::REG_A_COLS: a_cols_q <= cfg_data;
				mme_pkg::REG_B_ROWS: b_rows_q <= cfg_data;
				mme_pkg::REG_B_COLS: b_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ar_c = mme_pkg::clamp_dim(a_rows_q, MAX_D);
	assign ac_c = mme_pkg::clamp_dim(a_cols_q, MAX_D);
	assign br_c = mme_pkg::clamp_dim(b_rows_q, MAX_D);
	assign bc_c = mme_pkg::clamp_dim(b_cols_q, MAX_D);

	// ---------------------------------------------------------------- control
	mme_pkg::state_t state_q, state_d;
	logic adv;        // pipeline and output register move on
	logic issue;      // one MAC step read from the stores this cycle
	logic err_fire;   // error item loaded this cycle
	logic in_acc, start_acc, wr_ok;
	logic v_s1_q, v_s2_q;

	logic [mme_pkg::IDX_W-1:0] i_q, j_q, k_q;
	logic i_last, j_last, k_last;

	assign in_acc    = in_valid && in_ready;
	assign start_acc = in_acc && (kind == mme_pkg::KIND_START);
	assign wr_ok     = ({1'b0, row_index} < MAX_D) && ({1'b0, col_index} < MAX_D);

	// Output register free, or being emptied this cycle.
	assign adv = !out_valid || out_ready;

	assign i_last = ({1'b0, i_q} == mme_pkg::DIM_W'(ar_c - mme_pkg::DIM_W'(1)));
	assign j_last = ({1'b0, j_q} == mme_pkg::DIM_W'(bc_c - mme_pkg::DIM_W'(1)));
	assign k_last = ({1'b0, k_q} == mme_pkg::DIM_W'(ac_c - mme_pkg::DIM_W'(1)));

	always_comb begin
		state_d = state_q;
		case (state_q)
			mme_pkg::ST_IDLE: begin
				if (start_acc)
					state_d = (ac_c != br_c) ? mme_pkg::ST_ERR : mme_pkg::ST_RUN;
			end
			mme_pkg::ST_RUN: begin
				if (adv && i_last && j_last && k_last)
					state_d = mme_pkg::ST_IDLE;
			end
			mme_pkg::ST_ERR: begin
				if (err_fire)
					state_d = mme_pkg::ST_IDLE;
			end
			default: state_d = mme_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		err_fire = 1'b0;
		case (state_q)
			mme_pkg::ST_IDLE: in_ready = 1'b1;
			mme_pkg::ST_RUN:  issue    = adv;
			// wait for earlier products to drain so order is kept
			mme_pkg::ST_ERR:  err_fire = adv && !v_s1_q && !v_s2_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mme_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// i/j/k step counters, row-major over the product, k innermost
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (start_acc) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (issue) begin
			if (!k_last) begin
				k_q <= k_q + mme_pkg::IDX_W'(1);
			end else begin
				k_q <= '0;
				if (!j_last) begin
					j_q <= j_q + mme_pkg::IDX_W'(1);
				end else begin
					j_q <= '0;
					i_q <= i_q + mme_pkg::IDX_W'(1);
				end
			end
		end
	end

	// ---------------------------------------------------------------- stores
	logic [ADDR_W-1:0]  waddr, a_raddr, b_raddr;
	logic [STORE_W-1:0] a_rd, b_rd;
	logic               a_we, b_we;

	assign waddr   = ADDR_W'(32'(row_index) * MAX_DIM + 32'(col_index));
	assign a_raddr = ADDR_W'(32'(i_q) * MAX_DIM + 32'(k_q));
	assign b_raddr = ADDR_W'(32'(k_q) * MAX_DIM + 32'(j_q));
	assign a_we    = in_acc && wr_ok && (kind == mme_pkg::KIND_WR_A);
	assign b_we    = in_acc && wr_ok && (kind == mme_pkg::KIND_WR_B);

	mme_ram #(.WIDTH(STORE_W), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_a_store (
		.clk  (clk),
		.we   (a_we),
		.waddr(waddr),
		.wdata(element[STORE_W-1:0]),
		.re   (issue),
		.raddr(a_raddr),
		.rdata(a_rd)
	);

	mme_ram #(.WIDTH(STORE_W), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_b_store (
		.clk  (clk),
		.we   (b_we),
		.waddr(waddr),
		.wdata(element[STORE_W-1:0]),
		.re   (issue),
		.raddr(b_raddr),
		.rdata(b_rd)
	);

	// ---------------------------------------------------------------- MAC pipe
	// s1: store read data valid; s2: product registered; then accumulate.
	mme_pkg::mac_tag_t tag_s1, tag_s2;
	logic [MUL_W-1:0]           mul_s1;
	logic [mme_pkg::PROD_W-1:0] prod_s2;
	logic [mme_pkg::PROD_W-1:0] acc_q, acc_sum;

	assign mul_s1 = a_rd * b_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else if (adv) begin
			v_s1_q <= issue;
			v_s2_q <= v_s1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1.row       <= i_q;
			tag_s1.col       <= j_q;
			tag_s1.first     <= (k_q == '0);
			tag_s1.last_k    <= k_last;
			tag_s1.last_elem <= i_last && j_last;
			tag_s2           <= tag_s1;
			prod_s2          <= mme_pkg::PROD_W'(mul_s1);
		end
	end

	// wraps modulo 2^64
	assign acc_sum = (tag_s2.first ? '0 : acc_q) + prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_q <= '0;
		else if (adv && v_s2_q)
			acc_q <= acc_sum;
	end

	// ---------------------------------------------------------------- output
	logic                       out_valid_q;
	logic [mme_pkg::IDX_W-1:0]  out_row_q, out_col_q;
	logic [mme_pkg::PROD_W-1:0] product_q;
	logic                       last_q, dim_error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= (v_s2_q && tag_s2.last_k) || err_fire;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (v_s2_q && tag_s2.last_k) begin
				out_row_q   <= tag_s2.row;
				out_col_q   <= tag_s2.col;
				product_q   <= acc_sum;
				last_q      <= tag_s2.last_elem;
				dim_error_q <= 1'b0;
			end else if (err_fire) begin
				out_row_q   <= '0;
				out_col_q   <= '0;
				product_q   <= '0;
				last_q      <= 1'b1;
				dim_error_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign product   = product_q;
	assign last      = last_q;
	assign dim_error = dim_error_q;

endmodule

@@ design/mme_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker for the matrix multiply engine, bound to the top level.
module mme_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [mme_pkg::KIND_W-1:0]    kind,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [mme_pkg::IDX_W-1:0]     out_row,
	input logic [mme_pkg::IDX_W-1:0]     out_col,
	input logic [mme_pkg::PROD_W-1:0]    product,
	input logic                          last,
	input logic                          dim_error
);

	// an error item is alone in its run and carries no product
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dim_error |-> last && product == '0 && out_row == '0 && out_col == '0)
		else $error("error item malformed");

	// an accepted start item closes the input
	a_start_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == mme_pkg::KIND_START |=> !in_ready)
		else $error("input open right after start");

	// a stalled result item stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(product) && $stable(last)
			&& $stable(out_row) && $stable(out_col) && $stable(dim_error))
		else $error("result item changed while stalled");

endmodule

bind matrix_multiply_engine mme_chk u_mme_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.kind     (kind),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_row  (out_row),
	.out_col  (out_col),
	.product  (product),
	.last     (last),
	.dim_error(dim_error)
);

@@ bench/matrix_multiply_engine_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the matrix multiply engine: directed, random and stall tests.
module matrix_multiply_engine_test;

	localparam int                KIND_W        = mme_pkg::KIND_W;
	localparam int                IDX_W         = mme_pkg::IDX_W;
	localparam int                DIM_W         = mme_pkg::DIM_W;
	localparam int                ELEM_W        = mme_pkg::ELEM_W;
	localparam int                PROD_W        = mme_pkg::PROD_W;
	localparam int                CFG_IDX_W     = mme_pkg::CFG_IDX_W;
	localparam int                MAX_DIM       = mme_pkg::MAX_DIM_DEF;
	localparam int                STORE_DEPTH   = MAX_DIM * MAX_DIM;
	localparam int                ADDR_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	// kind code that the block must ignore
	localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd3;
	localparam logic [ELEM_W-1:0] ELEM_ONES     = '1;
	localparam int                SETTLE_CYCLES = 10;
	localparam int                LONG_HOLD     = 300;
	// sized for the worst case: every item a full 8x8x8 start with 64 results, each
	// result stalled by the sink and each item held back by a random gap
	localparam longint            RUN_LIMIT_NS  = 40_000_000;

	typedef struct packed {
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [PROD_W-1:0] product;
		logic              last;
		logic              dim_error;
	} product_item_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [KIND_W-1:0]    kind;
	logic [IDX_W-1:0]     row_index;
	logic [IDX_W-1:0]     col_index;
	logic [ELEM_W-1:0]    element;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;
	logic                 out_valid;
	logic                 out_ready;
	logic [IDX_W-1:0]     out_row;
	logic [IDX_W-1:0]     out_col;
	logic [PROD_W-1:0]    product;
	logic                 last;
	logic                 dim_error;

	// Predictor copy of the block: both stores, accumulator and dimension registers,
	// all updated at the edge where the matching handshake completes.
	logic [ELEM_W-1:0] a_model [STORE_DEPTH];
	logic [ELEM_W-1:0] b_model [STORE_DEPTH];
	logic [PROD_W-1:0] acc_model;
	logic [DIM_W-1:0]  dims_model [4];
	product_item_t     expected_products [$];

	// Stimulus side: what has been programmed and which entries hold data,
	// so that no multiply ever reads an entry never written.
	logic [DIM_W-1:0]  dims_prog [4];
	bit                a_written [STORE_DEPTH];
	bit                b_written [STORE_DEPTH];
	mme_pkg::reg_idx_t reg_order [4] = '{mme_pkg::REG_A_ROWS, mme_pkg::REG_A_COLS,
	                                     mme_pkg::REG_B_ROWS, mme_pkg::REG_B_COLS};

	int items_sent;
	int error_count;
	int hold_cycles;
	bit holding;
	bit quiet;

	matrix_multiply_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.row_index (row_index),
		.col_index (col_index),
		.element   (element),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_row   (out_row),
		.out_col   (out_col),
		.product   (product),
		.last      (last),
		.dim_error (dim_error)
	);

	initial begin : clock_gen
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Zero counts as one, anything past the store size as the store size.
	function automatic int effective_dim(input logic [DIM_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return int'(v);
	endfunction

	// Row-major store entry of one element.
	function automatic logic [ADDR_W-1:0] store_addr(input int r, input int c);
		return ADDR_W'(r * MAX_DIM + c);
	endfunction

	// Work out what one accepted item does to the stores and which results it causes.
	function automatic void predict_item(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] r,
	                                     input logic [IDX_W-1:0] c,
	                                     input logic [ELEM_W-1:0] value);
		int            ar;
		int            ac;
		int            br;
		int            bc;
		product_item_t res;
		case (k)
		mme_pkg::KIND_WR_A: a_model[{r, c}] = value;
		mme_pkg::KIND_WR_B: b_model[{r, c}] = value;
		mme_pkg::KIND_START: begin
			ar = effective_dim(dims_model[mme_pkg::REG_A_ROWS]);
			ac = effective_dim(dims_model[mme_pkg::REG_A_COLS]);
			br = effective_dim(dims_model[mme_pkg::REG_B_ROWS]);
			bc = effective_dim(dims_model[mme_pkg::REG_B_COLS]);
			if (ac != br) begin
				// shape mismatch: a single result flagged as error and last, everything else zero
				res           = '0;
				res.last      = 1'b1;
				res.dim_error = 1'b1;
				expected_products.push_back(res);
			end else begin
				for (int i = 0; i < ar; i++) begin
					for (int j = 0; j < bc; j++) begin
						acc_model = '0;
						for (int m = 0; m < ac; m++)
							acc_model += PROD_W'(a_model[store_addr(i, m)])
							           * PROD_W'(b_model[store_addr(m, j)]);
						res.row       = IDX_W'(i);
						res.col       = IDX_W'(j);
						res.product   = acc_model;
						res.last      = (i == ar - 1) && (j == bc - 1);
						res.dim_error = 1'b0;
						expected_products.push_back(res);
					end
				end
			end
		end
		default: ;
		endcase
	endfunction

	function automatic void compare_field(input string field, input logic [63:0] want,
	                                      input logic [63:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		end
	endfunction

	// Scoreboard: results are checked before the same edge's input is predicted,
	// since a start accepted now can never have a result out at this edge.
	always @(posedge clk) begin : scoreboard
		product_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_products.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result, expected none, actual row %0d col %0d %h",
					         $time, out_row, out_col, product);
				end else begin
					want = expected_products.pop_front();
					compare_field("out_row", 64'(want.row), 64'(out_row));
					compare_field("out_col", 64'(want.col), 64'(out_col));
					compare_field("product", want.product, product);
					compare_field("last", 64'(want.last), 64'(last));
					compare_field("dim_error", 64'(want.dim_error), 64'(dim_error));
				end
			end
			if (cfg_valid && cfg_ready)
				dims_model[cfg_index] = cfg_data;
			if (in_valid && in_ready)
				predict_item(kind, row_index, col_index, element);
		end
	end

	// Result sink: random ready bursts, or a long counted hold-off on request.
	initial begin : result_sink
		forever begin
			if (hold_cycles != 0) begin
				holding = 1'b1;
				out_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
				holding     = 1'b0;
			end else if (!quiet && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	function automatic logic [ELEM_W-1:0] random_element();
		case ($urandom_range(0, 7))
		0:       return '0;
		1:       return ELEM_ONES;
		default: return ELEM_W'($urandom);
		endcase
	endfunction

	// Offer one item and hold it until accepted. Valid is left high; the next call
	// or wait_idle decides whether it drops.
	task automatic send_item(input logic [KIND_W-1:0] item_kind, input logic [IDX_W-1:0] r,
	                         input logic [IDX_W-1:0] c, input logic [ELEM_W-1:0] value);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= item_kind;
		row_index <= r;
		col_index <= c;
		element   <= value;
		do @(posedge clk); while (!in_ready);
		case (item_kind)
		mme_pkg::KIND_WR_A: a_written[{r, c}] = 1'b1;
		mme_pkg::KIND_WR_B: b_written[{r, c}] = 1'b1;
		default: ;
		endcase
		if (item_kind != KIND_UNUSED)
			items_sent++;
	endtask

	// Drop valid and let every expected result drain, then wait out the settle margin.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_products.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Program all four dimension registers, only ever from idle.
	task automatic configure(input logic [DIM_W-1:0] ar, input logic [DIM_W-1:0] ac,
	                         input logic [DIM_W-1:0] br, input logic [DIM_W-1:0] bc);
		logic [DIM_W-1:0] values [4];
		values = '{ar, ac, br, bc};
		wait_idle();
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= reg_order[CFG_IDX_W'(i)];
			cfg_data  <= values[CFG_IDX_W'(i)];
			do @(posedge clk); while (!cfg_ready);
			dims_prog[reg_order[CFG_IDX_W'(i)]] = values[CFG_IDX_W'(i)];
		end
		cfg_valid <= 1'b0;
	endtask

	// Start a multiply, first filling any entry the product would read that is still empty.
	task automatic start_product();
		int ar;
		int ac;
		int br;
		int bc;
		ar = effective_dim(dims_prog[mme_pkg::REG_A_ROWS]);
		ac = effective_dim(dims_prog[mme_pkg::REG_A_COLS]);
		br = effective_dim(dims_prog[mme_pkg::REG_B_ROWS]);
		bc = effective_dim(dims_prog[mme_pkg::REG_B_COLS]);
		if (ac == br) begin
			for (int i = 0; i < ar; i++)
				for (int m = 0; m < ac; m++)
					if (!a_written[store_addr(i, m)])
						send_item(mme_pkg::KIND_WR_A, IDX_W'(i), IDX_W'(m), random_element());
			for (int m = 0; m < ac; m++)
				for (int j = 0; j < bc; j++)
					if (!b_written[store_addr(m, j)])
						send_item(mme_pkg::KIND_WR_B, IDX_W'(m), IDX_W'(j), random_element());
		end
		send_item(mme_pkg::KIND_START, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
	endtask

	// Mostly element writes with random content and starts, a little unused-kind noise.
	task automatic random_traffic(input int count);
		int target;
		int pick;
		target = items_sent + count;
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 6)
				send_item(KIND_UNUSED, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
			else if (pick < 20)
				start_product();
			else if (pick < 60)
				send_item(mme_pkg::KIND_WR_A, IDX_W'($urandom), IDX_W'($urandom),
				          random_element());
			else
				send_item(mme_pkg::KIND_WR_B, IDX_W'($urandom), IDX_W'($urandom),
				          random_element());
		end
	endtask

	task automatic test_directed();
		// reset shape is 1x1x1: widest elements give the widest single product
		send_item(mme_pkg::KIND_WR_A, '0, '0, ELEM_ONES);
		send_item(mme_pkg::KIND_WR_B, '0, '0, ELEM_ONES);
		send_item(mme_pkg::KIND_START, '0, '0, '0);
		// unused kind must leave both stores untouched
		send_item(KIND_UNUSED, '0, '0, '0);
		send_item(mme_pkg::KIND_START, IDX_W'(7), IDX_W'(7), ELEM_ONES);
		// far corner of both stores
		send_item(mme_pkg::KIND_WR_A, IDX_W'(7), IDX_W'(7), '0);
		send_item(mme_pkg::KIND_WR_B, IDX_W'(7), IDX_W'(7), ELEM_ONES);
		// columns of A differ from rows of B: error result only
		configure(DIM_W'(1), DIM_W'(2), DIM_W'(3), DIM_W'(1));
		send_item(mme_pkg::KIND_START, '0, '0, '0);
		// zero in every register reads as one
		configure('0, '0, '0, '0);
		send_item(mme_pkg::KIND_START, '0, '0, '0);
		// a_cols of 15 clamps to 8 and matches b_rows: eight full-width terms wrap
		configure(DIM_W'(1), DIM_W'(15), DIM_W'(8), DIM_W'(1));
		for (int m = 1; m < MAX_DIM; m++) begin
			send_item(mme_pkg::KIND_WR_A, '0, IDX_W'(m), ELEM_ONES);
			send_item(mme_pkg::KIND_WR_B, IDX_W'(m), '0, ELEM_ONES);
		end
		send_item(mme_pkg::KIND_START, '0, '0, '0);
	endtask

	task automatic test_random_shapes();
		logic [DIM_W-1:0] ar;
		logic [DIM_W-1:0] ac;
		logic [DIM_W-1:0] br;
		logic [DIM_W-1:0] bc;
		configure(DIM_W'(1), DIM_W'(1), DIM_W'(1), DIM_W'(1));
		random_traffic(25);
		configure(DIM_W'(8), DIM_W'(8), DIM_W'(8), DIM_W'(8));
		random_traffic(25);
		// every register above the limit: all clamp to the full 8x8x8
		configure(DIM_W'(15), DIM_W'(12), DIM_W'(9), DIM_W'(15));
		random_traffic(25);
		repeat (6) begin
			ac = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(0, 15))
			                                 : DIM_W'($urandom_range(1, 4));
			// mostly matching shapes so products dominate over error results
			br = ($urandom_range(0, 9) < 7) ? ac : DIM_W'($urandom_range(0, 15));
			ar = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(0, 15))
			                                 : DIM_W'($urandom_range(1, 4));
			bc = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(0, 15))
			                                 : DIM_W'($urandom_range(1, 4));
			configure(ar, ac, br, bc);
			random_traffic(30);
		end
	endtask

	// Sink holds off while starts keep coming, so the block backs up into its input.
	task automatic test_back_pressure();
		configure(DIM_W'(4), DIM_W'(4), DIM_W'(4), DIM_W'(4));
		hold_cycles = LONG_HOLD;
		while (!holding) @(posedge clk);
		start_product();
		repeat (4)
			send_item(mme_pkg::KIND_WR_B, IDX_W'($urandom), IDX_W'($urandom), random_element());
		start_product();
		start_product();
		// sender pauses until everything has drained
		wait_idle();
	endtask

	// Final stretch with no idling on either side.
	task automatic test_streaming();
		quiet = 1'b1;
		configure(DIM_W'(3), DIM_W'(5), DIM_W'(5), DIM_W'(2));
		random_traffic(100);
		configure(DIM_W'(8), DIM_W'(1), DIM_W'(1), DIM_W'(8));
		random_traffic(40);
	endtask

	initial begin : run_sequence
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		kind       <= mme_pkg::KIND_WR_A;
		row_index  <= '0;
		col_index  <= '0;
		element    <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= mme_pkg::REG_A_ROWS;
		cfg_data   <= '0;
		dims_model = '{default: DIM_W'(1)};
		dims_prog  = '{default: DIM_W'(1)};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_shapes();
		test_back_pressure();
		test_streaming();
		wait_idle();

		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
design/mme_pkg.sv
design/mme_ram.sv
design/matrix_multiply_engine.sv
design/mme_chk.sv
bench/matrix_multiply_engine_test.sv
